// ===== sv/frmi_pkg.sv =====
// Package for the frame rotate / mirror / invert block.
// Holds the sizes, operation and register codes and the depth mask helper.
// No dependencies.
package frmi_pkg;

	localparam int unsigned MAX_DIM     = 256;
	localparam int unsigned PIXEL_BITS  = 24;
	localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned LOAD_W      = $clog2(STORE_DEPTH + 1);
	localparam int unsigned DIM_W       = $clog2(MAX_DIM + 1);
	localparam int unsigned CNT_W       = $clog2(MAX_DIM);
	localparam int unsigned CFG_W       = DIM_W;

	typedef logic [PIXEL_BITS-1:0] pixel_t;

	typedef enum logic [1:0] {
		OP_MIRROR = 2'd0,
		OP_ROTATE = 2'd1,
		OP_INVERT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_OPERATION    = 2'd0,
		REG_DEPTH_CODE   = 2'd1,
		REG_FRAME_WIDTH  = 2'd2,
		REG_FRAME_HEIGHT = 2'd3
	} reg_index_t;

	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_DRAIN = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		DEPTH_1  = 3'd0,
		DEPTH_2  = 3'd1,
		DEPTH_4  = 3'd2,
		DEPTH_8  = 3'd3,
		DEPTH_16 = 3'd4,
		DEPTH_24 = 3'd5
	} depth_t;

	// Status of a drain item waiting on its store read.
	typedef struct packed {
		logic valid;
		logic row_end;
		logic frame_end;
	} drain_ctl_t;

	// Mask for the given bits-per-pixel code; unused codes act as 24 bits.
	function automatic pixel_t depth_mask(input logic [2:0] code);
		pixel_t m;
		m = '1;
		case (code)
			DEPTH_1:  m = pixel_t'(24'h000001);
			DEPTH_2:  m = pixel_t'(24'h000003);
			DEPTH_4:  m = pixel_t'(24'h00000F);
			DEPTH_8:  m = pixel_t'(24'h0000FF);
			DEPTH_16: m = pixel_t'(24'h00FFFF);
			default:  m = pixel_t'(24'hFFFFFF);
		endcase
		return m;
	endfunction

endpackage

// ===== sv/frame_rotate_mirror_invert_top.sv =====
// Top level of the frame rotate / mirror / invert block.
// Uses frmi_pkg and the frmi_ram frame store.
//
// Usage:
// The input channel (in_valid / in_ready) carries one item per handshake. An
// item with mode load writes pixel_in, masked to the pixel depth, into the
// frame store at the next raster position; once width * height pixels are
// stored, further loads are dropped until the frame has been drained. An item
// with mode drain reads one output pixel in output raster order and returns
// it on the output channel (out_valid / out_ready) with row_end and frame_end.
// The last drain of a frame returns all counters to zero for the next frame.
// A drain passes through the registered store read and then the result
// register before out_valid rises. A load gives no result. One item can be
// accepted in every cycle while in_ready is high; the single read and
// single write port of the frame store set that rate.
// When the receiver stalls, the result register holds its item and one more
// drain can wait behind it on the store read; only then does in_ready drop.
// Configuration is written through cfg_we / cfg_index / cfg_data while no
// items are in flight. Reset clears the counters and the pipeline and sets
// mirror, 8 bits per pixel and a 256 x 256 frame. The frame store is not
// cleared; a frame must be loaded before it is drained.
module frame_rotate_mirror_invert_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic [23:0]                       pixel_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [23:0]                       pixel_out,
	output logic                              row_end,
	output logic                              frame_end,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [frmi_pkg::CFG_W-1:0]        cfg_data
);

	localparam int unsigned ADDR_W = frmi_pkg::ADDR_W;
	localparam int unsigned LOAD_W = frmi_pkg::LOAD_W;
	localparam int unsigned DIM_W  = frmi_pkg::DIM_W;
	localparam int unsigned CNT_W  = frmi_pkg::CNT_W;

	// Configuration registers.
	logic [1:0]       operation_q;
	logic [2:0]       depth_code_q;
	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;

	// Frame counters.
	logic [LOAD_W-1:0] load_index_q;
	logic [CNT_W-1:0]  drain_row_q;
	logic [CNT_W-1:0]  drain_col_q;

	// Pipeline: store read stage and result register.
	frmi_pkg::drain_ctl_t ctl_s1;
	logic                 out_valid_s2;
	frmi_pkg::pixel_t     pixel_s2;
	logic                 row_end_s2;
	logic                 frame_end_s2;

	logic [DIM_W-1:0]  width_c;
	logic [DIM_W-1:0]  height_c;
	logic [DIM_W-1:0]  out_width;
	logic [DIM_W-1:0]  out_height;
	logic [LOAD_W-1:0] frame_size;
	logic [ADDR_W-1:0] src_row;
	logic [ADDR_W-1:0] src_col;
	logic [ADDR_W-1:0] rd_addr;
	logic              is_rotate;
	logic              is_invert;
	logic              rend;
	logic              fend;
	logic              in_acc;
	logic              load_acc;
	logic              drain_acc;
	logic              store_we;
	logic              s1_adv;
	frmi_pkg::pixel_t  mask;
	frmi_pkg::pixel_t  store_rdata;
	frmi_pkg::pixel_t  pixel_res;

	// Dimensions clamped to 1 .. MAX_DIM.
	always_comb begin
		width_c  = frame_width_q;
		height_c = frame_height_q;
		if (frame_width_q == '0) begin
			width_c = DIM_W'(1);
		end else if (frame_width_q > DIM_W'(frmi_pkg::MAX_DIM)) begin
			width_c = DIM_W'(frmi_pkg::MAX_DIM);
		end
		if (frame_height_q == '0) begin
			height_c = DIM_W'(1);
		end else if (frame_height_q > DIM_W'(frmi_pkg::MAX_DIM)) begin
			height_c = DIM_W'(frmi_pkg::MAX_DIM);
		end
	end

	assign frame_size = LOAD_W'(LOAD_W'(width_c) * LOAD_W'(height_c));
	assign mask       = frmi_pkg::depth_mask(depth_code_q);
	assign is_rotate  = (operation_q == frmi_pkg::OP_ROTATE);
	assign is_invert  = (operation_q[1] == 1'b1);
	assign out_width  = is_rotate ? height_c : width_c;
	assign out_height = is_rotate ? width_c : height_c;

	// Source coordinates in the input frame. Arithmetic wraps at the store
	// depth, as does the address itself.
	always_comb begin
		src_row = ADDR_W'(drain_row_q);
		src_col = ADDR_W'(drain_col_q);
		unique case (operation_q)
			frmi_pkg::OP_MIRROR: begin
				src_row = ADDR_W'(drain_row_q);
				src_col = ADDR_W'(width_c) - ADDR_W'(1) - ADDR_W'(drain_col_q);
			end
			frmi_pkg::OP_ROTATE: begin
				src_row = ADDR_W'(height_c) - ADDR_W'(1) - ADDR_W'(drain_col_q);
				src_col = ADDR_W'(drain_row_q);
			end
			default: begin
				src_row = ADDR_W'(drain_row_q);
				src_col = ADDR_W'(drain_col_q);
			end
		endcase
	end

	assign rd_addr = ADDR_W'(src_row * ADDR_W'(width_c)) + src_col;

	// A column counter at or past the last column ends the row; the frame
	// ends on a row end in the last row or beyond it.
	assign rend = ((DIM_W'(drain_col_q) + DIM_W'(1)) >= out_width);
	assign fend = rend && ((DIM_W'(drain_row_q) + DIM_W'(1)) >= out_height);

	// Handshake. The read stage moves on when the result register is free
	// or being emptied, and the input waits only when the read stage is stuck.
	assign s1_adv    = ctl_s1.valid && (!out_valid_s2 || out_ready);
	assign in_ready  = !ctl_s1.valid || s1_adv;
	assign in_acc    = in_valid && in_ready;
	assign load_acc  = in_acc && (mode == frmi_pkg::MODE_LOAD);
	assign drain_acc = in_acc && (mode == frmi_pkg::MODE_DRAIN);
	assign store_we  = load_acc && (load_index_q < frame_size);

	frmi_ram #(
		.DATA_W (frmi_pkg::PIXEL_BITS),
		.DEPTH  (frmi_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (load_index_q[ADDR_W-1:0]),
		.wdata (pixel_in & mask),
		.re    (drain_acc),
		.raddr (rd_addr),
		.rdata (store_rdata)
	);

	assign pixel_res = (is_invert ? ~store_rdata : store_rdata) & mask;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operation_q    <= frmi_pkg::OP_MIRROR;
			depth_code_q   <= frmi_pkg::DEPTH_8;
			frame_width_q  <= DIM_W'(frmi_pkg::MAX_DIM);
			frame_height_q <= DIM_W'(frmi_pkg::MAX_DIM);
		end else if (cfg_we) begin
			unique case (cfg_index)
				frmi_pkg::REG_OPERATION:    operation_q    <= cfg_data[1:0];
				frmi_pkg::REG_DEPTH_CODE:   depth_code_q   <= cfg_data[2:0];
				frmi_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				frmi_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Load and drain counters. The last drain of a frame also rewinds the
	// load position so the next frame can be loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_index_q <= '0;
			drain_row_q  <= '0;
			drain_col_q  <= '0;
		end else begin
			if (store_we) begin
				load_index_q <= load_index_q + LOAD_W'(1);
			end
			if (drain_acc) begin
				if (fend) begin
					drain_row_q  <= '0;
					drain_col_q  <= '0;
					load_index_q <= '0;
				end else if (rend) begin
					drain_col_q <= '0;
					drain_row_q <= drain_row_q + CNT_W'(1);
				end else begin
					drain_col_q <= drain_col_q + CNT_W'(1);
				end
			end
		end
	end

	// Store read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (in_ready) begin
			ctl_s1.valid     <= drain_acc;
			ctl_s1.row_end   <= rend;
			ctl_s1.frame_end <= fend;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_s2     <= pixel_res;
			row_end_s2   <= ctl_s1.row_end;
			frame_end_s2 <= ctl_s1.frame_end;
		end
	end

	assign out_valid = out_valid_s2;
	assign pixel_out = pixel_s2;
	assign row_end   = row_end_s2;
	assign frame_end = frame_end_s2;

endmodule

// ===== sv/frmi_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module frmi_ram #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/frmi_checker.sv =====
// Port-level checks for the frame rotate / mirror / invert block.
// Uses frmi_pkg; bound to frame_rotate_mirror_invert_top.
module frmi_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       mode,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [23:0]                pixel_out,
	input logic                       row_end,
	input logic                       frame_end
);

	// The output is empty while reset is held.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// A frame ends only at the end of a row.
	a_frame_on_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> row_end)
		else $error("frame_end without row_end");

	// The input waits only when a result is held back by the receiver.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("in_ready low without output stall");

	// A drain taken while the output is empty shows up after the store read and the result register.
	a_drain_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (mode == frmi_pkg::MODE_DRAIN) && !out_valid)
		|-> ##2 out_valid)
		else $error("drain result missing");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pixel_out)))
		else $error("stalled result changed");

endmodule

bind frame_rotate_mirror_invert_top frmi_checker u_frmi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.mode      (mode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pixel_out (pixel_out),
	.row_end   (row_end),
	.frame_end (frame_end)
);
